/* rtl/csls_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csls_pkg
// Shared types and constants for the charge status LED sequencer.
// ----------------------------------------------------------------------------
package csls_pkg;

    localparam int MV_W       = 13;
    localparam int PCT_W      = 7;
    localparam int DIVIDEND_W = 20;
    localparam int QUO_W      = 9;
    localparam int STEP_W     = 4;
    localparam int DIV_SHIFT  = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int PADDR_W     = 4;

    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [7:0]       START_BLINKS = 8'd10;
    localparam logic [3:0]       PAUSE_TICKS  = 4'd8;

    // register indexes on the APB port
    localparam logic [1:0] REG_EMPTY_MV = 2'd0;
    localparam logic [1:0] REG_FULL_MV  = 2'd1;
    localparam logic [1:0] REG_LOW_PCT  = 2'd2;

    localparam logic [MV_W-1:0]  EMPTY_MV_RST = 13'd3300;
    localparam logic [MV_W-1:0]  FULL_MV_RST  = 13'd4200;
    localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd5;

    typedef enum logic [1:0] {
        PAT_OFF    = 2'd0,
        PAT_ON     = 2'd1,
        PAT_START  = 2'd2,
        PAT_DOUBLE = 2'd3
    } pattern_t;

    typedef enum logic [2:0] {
        MODE_DISC = 3'd0,
        MODE_CONN = 3'd1,
        MODE_LOW  = 3'd2,
        MODE_CHG  = 3'd3,
        MODE_DONE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_APPLY
    } seq_state_t;

    typedef struct packed {
        logic            vibration_active;
        logic [MV_W-1:0] battery_mv;
        logic            supply_detect_pin;
        logic            charge_done_pin;
        logic            link_connected;
    } tick_in_t;

    typedef struct packed {
        logic [7:0] tick;
        pattern_t   pattern;
        logic       phase_on;
        logic [7:0] blink_count;
        logic [1:0] db_stage;
        logic [3:0] db_wait;
        mode_t      mode;
        mode_t      last_mode;
        logic       started;
        logic       level;
    } led_state_t;

    typedef struct packed {
        logic  stop_vibration;
        logic  start_charge_work;
        mode_t mode;
        logic  led_on;
    } led_result_t;

    function automatic led_state_t load_pattern(led_state_t s, pattern_t p);
        led_state_t r;
        r = s;
        if (p == PAT_START) begin
            r.blink_count = '0;
        end else if (p == PAT_DOUBLE) begin
            r.db_stage = '0;
        end
        r.phase_on = 1'b0;
        r.pattern  = p;
        r.tick     = '0;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/charge_status_led_sequencer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// charge_status_led_sequencer_unit
// Per-tick LED pattern and system mode sequencer with battery percentage.
// ----------------------------------------------------------------------------
// One input transfer is one LED tick. The block takes one tick at a time:
// s_tready is high only while idle, and a tick occupies it through PREP,
// DIV (skipped when battery_empty_mv is not below battery_full_mv) and
// APPLY; DIV runs the nine-step bit-serial divider that forms the battery
// percentage. The result sits in an output register, so the next tick is
// taken while it waits; a result still stalled holds the next in APPLY.
module charge_status_led_sequencer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // [0] link_connected, [1] charge_done_pin, [2] supply_detect_pin,
    // [15:3] battery_mv, [16] vibration_active, [23:17] zero
    input  wire logic [csls_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [0] led_on, [3:1] system_mode, [10:4] battery_percent,
    // [11] start_charge_work, [12] stop_vibration, [15:13] zero
    output logic [csls_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [csls_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import csls_pkg::*;

    seq_state_t state_reg, state_next;

    logic [MV_W-1:0]  empty_mv_reg;
    logic [MV_W-1:0]  full_mv_reg;
    logic [PCT_W-1:0] low_pct_reg;

    tick_in_t         in_reg;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic             m_tvalid_reg;

    logic             cfg_wr;
    logic [1:0]       reg_idx;

    logic [MV_W-1:0]       mv_diff;
    logic [DIVIDEND_W-1:0] dividend;
    logic [MV_W-1:0]       divisor;
    logic                  div_start;
    logic                  div_done;
    logic [QUO_W-1:0]      quotient;
    logic                  degenerate;
    logic                  apply_en;
    led_result_t           led_res;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_mv_reg <= EMPTY_MV_RST;
            full_mv_reg  <= FULL_MV_RST;
            low_pct_reg  <= LOW_PCT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_EMPTY_MV: empty_mv_reg <= pwdata[MV_W-1:0];
                REG_FULL_MV:  full_mv_reg  <= pwdata[MV_W-1:0];
                REG_LOW_PCT:  low_pct_reg  <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EMPTY_MV: prdata = 32'(empty_mv_reg);
            REG_FULL_MV:  prdata = 32'(full_mv_reg);
            REG_LOW_PCT:  prdata = 32'(low_pct_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- percentage datapath ----------------
    assign degenerate = full_mv_reg <= empty_mv_reg;
    assign mv_diff    = (in_reg.battery_mv < empty_mv_reg) ? '0
                      : in_reg.battery_mv - empty_mv_reg;
    // x100 = x64 + x32 + x4
    assign dividend   = DIVIDEND_W'({mv_diff, 6'b0}) + DIVIDEND_W'({mv_diff, 5'b0})
                      + DIVIDEND_W'({mv_diff, 2'b0});
    assign divisor    = full_mv_reg - empty_mv_reg;
    assign div_start  = (state_reg == ST_PREP) && !degenerate;

    csls_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    csls_led_ctrl u_led (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (apply_en),
        .tick_in (in_reg),
        .pct     (pct_reg),
        .low_pct (low_pct_reg),
        .result  (led_res)
    );

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign apply_en = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        pct_next   = pct_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (degenerate) begin
                    pct_next   = (in_reg.battery_mv > empty_mv_reg) ? PCT_FULL : '0;
                    state_next = ST_APPLY;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pct_next   = (quotient > QUO_W'(PCT_FULL)) ? PCT_FULL
                               : quotient[PCT_W-1:0];
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_en) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pct_reg <= pct_next;
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[$bits(tick_in_t)-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_en) begin
            m_tdata_reg <= {3'b000, led_res.stop_vibration, led_res.start_charge_work,
                            pct_reg, led_res.mode, led_res.led_on};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* rtl/csls_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csls_div
// Restoring divider, one quotient bit per cycle, nine bits (saturation is
// left to the caller).
// ----------------------------------------------------------------------------
module csls_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [csls_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [csls_pkg::MV_W-1:0]       divisor,
    output logic                               done,
    output logic [csls_pkg::QUO_W-1:0]           quotient
);
    import csls_pkg::*;

    localparam int DS_W = MV_W + DIV_SHIFT;

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DS_W-1:0]       ds_reg;
    logic [QUO_W-1:0]      q_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DS_W-1:0]       rem_ext;
    logic [DS_W-1:0]       diff;
    logic                  ge;

    // shared compare/subtract
    assign rem_ext = DS_W'(rem_reg);
    assign ge      = rem_ext >= ds_reg;
    assign diff    = rem_ext - ds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= dividend;
                ds_reg   <= {divisor, {DIV_SHIFT{1'b0}}};
                q_reg    <= '0;
                step_reg <= STEP_W'(DIV_SHIFT);
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= diff[DIVIDEND_W-1:0];
                end
                q_reg  <= {q_reg[QUO_W-2:0], ge};
                ds_reg <= ds_reg >> 1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

/* rtl/csls_led_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csls_led_ctrl
// LED pattern sequencer and system mode tracker, advanced once per tick.
// ----------------------------------------------------------------------------
module csls_led_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en,
    input  wire csls_pkg::tick_in_t        tick_in,
    input  wire logic [csls_pkg::PCT_W-1:0] pct,
    input  wire logic [csls_pkg::PCT_W-1:0] low_pct,
    output csls_pkg::led_result_t          result
);
    import csls_pkg::*;

    led_state_t st_reg;
    led_state_t st_next;

    always_comb begin
        led_state_t s;
        logic       strobe_chg;
        logic       strobe_stop;
        s           = st_reg;
        strobe_chg  = 1'b0;
        strobe_stop = 1'b0;
        s.tick      = st_reg.tick + 8'd1;

        case (s.pattern)
            PAT_OFF: s.level = 1'b0;
            PAT_ON:  s.level = 1'b1;
            PAT_START: begin
                if (!s.tick[0]) begin
                    if (!s.phase_on) begin
                        s.level    = 1'b1;
                        s.phase_on = 1'b1;
                    end else begin
                        s.level       = 1'b0;
                        s.phase_on    = 1'b0;
                        s.blink_count = s.blink_count + 8'd1;
                    end
                    if (s.blink_count > START_BLINKS) begin
                        case (s.mode)
                            MODE_DISC: s = load_pattern(s, PAT_OFF);
                            MODE_LOW:  s = load_pattern(s, PAT_DOUBLE);
                            default:   s = load_pattern(s, PAT_ON);
                        endcase
                    end
                end
            end
            default: begin
                if (s.db_stage < 2'd2) begin
                    if (!s.phase_on) begin
                        s.level    = 1'b1;
                        s.phase_on = 1'b1;
                    end else begin
                        s.level    = 1'b0;
                        s.phase_on = 1'b0;
                        s.db_stage = s.db_stage + 2'd1;
                        s.db_wait  = '0;
                    end
                end else if (s.db_stage == 2'd2) begin
                    s.db_wait = s.db_wait + 4'd1;
                    if (s.db_wait > PAUSE_TICKS) begin
                        s.db_stage = '0;
                    end
                end
            end
        endcase

        // mode check every fourth tick
        if (s.tick[1:0] == 2'b00) begin
            if (s.started && s.pattern != PAT_START) begin
                s.mode = tick_in.link_connected ? MODE_CONN : MODE_DISC;
                if (!tick_in.charge_done_pin && !tick_in.supply_detect_pin) begin
                    s.mode = MODE_DONE;
                end else if (!tick_in.supply_detect_pin) begin
                    s.mode = MODE_CHG;
                end else if (pct < low_pct) begin
                    s.mode = MODE_LOW;
                end
            end
            if (s.last_mode != s.mode) begin
                s.last_mode = s.mode;
                case (s.mode)
                    MODE_DISC: s = load_pattern(s, PAT_OFF);
                    MODE_LOW:  s = load_pattern(s, PAT_DOUBLE);
                    MODE_CHG: begin
                        s          = load_pattern(s, PAT_ON);
                        strobe_chg = 1'b1;
                    end
                    MODE_DONE: s = load_pattern(s, PAT_OFF);
                    default:   s = load_pattern(s, PAT_ON);
                endcase
                strobe_stop = (s.mode != MODE_CHG) && tick_in.vibration_active;
            end
            if (!s.started) begin
                s.started = 1'b1;
                s         = load_pattern(s, PAT_START);
            end
        end

        st_next                  = s;
        result.led_on            = s.level;
        result.mode              = s.mode;
        result.start_charge_work = strobe_chg;
        result.stop_vibration    = strobe_stop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{tick: '0, pattern: PAT_OFF, phase_on: 1'b0, blink_count: '0,
                        db_stage: '0, db_wait: '0, mode: MODE_DISC,
                        last_mode: MODE_DISC, started: 1'b0, level: 1'b0};
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/csls_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csls_checker
// Port-level checks for the charge status LED sequencer.
// ----------------------------------------------------------------------------
module csls_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one tick in flight: busy right after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a tick is in work");

    // charging strobe and vibration stop are exclusive
    a_strobe_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[11] && m_tdata[12]))
        else $error("both strobes set");

    // percentage saturates and mode code stays in range
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:4] <= 7'd100) && (m_tdata[3:1] <= 3'd4))
        else $error("result field out of range");

endmodule

bind charge_status_led_sequencer_unit csls_checker u_csls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
